// ----- rtl/core/itda_pkg.sv -----
// Shared types and constants for the signed integer to decimal ASCII converter.
// Used by the controller, the datapath and the top level; depends on nothing.
package itda_pkg;

    localparam int MAG_W   = 32;
    localparam int DIGITS  = 10;
    localparam int BCD_W   = 4 * DIGITS;
    localparam int PTR_W   = 4;
    localparam int CNT_W   = 5;
    localparam int CHAR_W  = 7;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;
    localparam logic [CNT_W-1:0]  SHIFT_LAST  = 5'd31;

    typedef struct packed {
        logic load;
        logic shift;
        logic set_ptr;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    typedef struct packed {
        logic neg;
        logic ptr_zero;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/core/itda_ctrl.sv -----
// Sequencing state machine for the converter.
// Depends on itda_pkg; drives the datapath through t_cmd and reads t_sts.
module itda_ctrl
    import itda_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CONV  = 2'd1;
    localparam logic [1:0] S_SIGN  = 2'd2;
    localparam logic [1:0] S_DIGIT = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.shift = 1'b1;
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == SHIFT_LAST) begin
                    n_state = S_SIGN;
                end
            end
            S_SIGN: begin
                o_cmd.set_ptr = 1'b1;
                if (!i_sts.neg) begin
                    n_state = S_DIGIT;
                end else if (i_sts.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_sts.ptr_zero) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ----- rtl/core/itda_dp.sv -----
// Datapath: magnitude register, shift-and-add-3 BCD register, digit pointer
// and output register. Depends on itda_pkg; controlled by itda_ctrl.
module itda_dp
    import itda_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [MAG_W-1:0]  i_value,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CHAR_W-1:0] o_character,
    output logic              o_last
);

    logic [MAG_W-1:0]  r_mag, n_mag;
    logic              r_neg, n_neg;
    logic [BCD_W-1:0]  r_bcd, n_bcd;
    logic [BCD_W-1:0]  w_adj;
    logic [PTR_W-1:0]  r_ptr, n_ptr;
    logic [PTR_W-1:0]  w_top;
    logic              r_o_valid, n_o_valid;
    logic [CHAR_W-1:0] r_char, n_char;
    logic              r_last, n_last;
    logic [3:0]        w_digit;

    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_comb begin
        w_top = '0;
        for (int i = 0; i < DIGITS; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                w_top = PTR_W'(i);
            end
        end
    end

    assign w_digit = r_bcd[{r_ptr, 2'b00} +: 4];

    always_comb begin
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_bcd     = r_bcd;
        n_ptr     = r_ptr;
        n_o_valid = r_o_valid;
        n_char    = r_char;
        n_last    = r_last;
        if (i_cmd.load) begin
            n_neg = i_value[MAG_W-1];
            n_mag = i_value[MAG_W-1] ? (MAG_W'(0) - i_value) : i_value;
            n_bcd = '0;
        end
        if (i_cmd.shift) begin
            n_bcd = {w_adj[BCD_W-2:0], r_mag[MAG_W-1]};
            n_mag = {r_mag[MAG_W-2:0], 1'b0};
        end
        if (i_cmd.set_ptr) begin
            n_ptr = w_top;
        end
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end
        if (i_cmd.emit_sign) begin
            n_o_valid = 1'b1;
            n_char    = ASCII_MINUS;
            n_last    = 1'b0;
        end
        if (i_cmd.emit_digit) begin
            n_o_valid = 1'b1;
            n_char    = ASCII_ZERO + {3'b000, w_digit};
            n_last    = (r_ptr == '0);
            n_ptr     = r_ptr - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
        end
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_bcd  <= n_bcd;
        r_ptr  <= n_ptr;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_sts.neg      = r_neg;
    assign o_sts.ptr_zero = (r_ptr == '0);
    assign o_sts.out_free = !r_o_valid || i_ready;

    assign o_valid     = r_o_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

endmodule

// ----- rtl/core/int_to_decimal_ascii.sv -----
// Top level of the signed 32-bit integer to decimal ASCII converter.
// Depends on itda_pkg and instantiates itda_ctrl and itda_dp.
//
// Usage:
// The input channel (i_valid, o_ready, i_value) takes one signed 32-bit
// integer per beat. The output channel (o_valid, i_ready, o_character,
// o_last) returns its decimal text one ASCII character per beat, most
// significant digit first, with a leading '-' for negative values and
// o_last set on the final character. Zero gives the single character '0'.
// After a beat is taken, the magnitude is converted to BCD by serial
// shift-and-add-3, one bit per cycle, then the leading digit is picked.
// A negative value's '-' is emitted before the first digit, and further
// characters follow one per cycle while the receiver keeps i_ready high.
// The block takes no new integer before the item is done: o_ready is low
// for the whole item and returns while the final character may still wait
// in the output register.
// When the receiver holds i_ready low, the output register keeps its beat
// and the sequencer waits. Reset empties the output register and returns
// the sequencer to idle; a partly converted item is dropped.
module int_to_decimal_ascii
    import itda_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [MAG_W-1:0]  i_value,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CHAR_W-1:0] o_character,
    output logic              o_last
);

    t_cmd w_cmd;
    t_sts w_sts;

    itda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    itda_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

// ----- rtl/core/itda_chk.sv -----
// Port-level checker for the converter, bound to the top level.
// Depends on itda_pkg for the character codes.
module itda_chk
    import itda_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic [CHAR_W-1:0] o_character,
    input logic              o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("Output beat dropped while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_character) && $stable(o_last))
        else $error("Output payload changed while stalled.");

    a_char_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_character == ASCII_MINUS) ||
                    ((o_character >= ASCII_ZERO) && (o_character <= ASCII_ZERO + 7'd9)))
        else $error("Output character is neither a sign nor a digit.");

    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_character == ASCII_MINUS) |-> !o_last)
        else $error("Sign character marked as last.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("Input accepted again right after an accepted beat.");

endmodule

bind int_to_decimal_ascii itda_chk u_itda_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_character (o_character),
    .o_last      (o_last)
);
